// ===== src/bitmap_presence_sort_top_macros.svh =====
// Assertion macros for the bitmap presence sort checker.
// No dependencies; included by the checker file only.
`ifndef BITMAP_PRESENCE_SORT_TOP_MACROS_SVH
`define BITMAP_PRESENCE_SORT_TOP_MACROS_SVH

// Implication checked at every rising edge outside reset
`define BPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap presence sort: implication check failed");

// Condition that must never be seen outside reset
`define BPS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bitmap presence sort: forbidden condition seen");

`endif

// ===== src/bps_pkg.sv =====
// Shared constants and types for the bitmap presence sort block.
// No dependencies; imported by every module of the block.
package bps_pkg;

	// Default signed value width and the fixed bitmap word width
	localparam int VALUE_BITS_DEF = 16;
	localparam int WORD_BITS      = 32;
	localparam int WORD_SEL_BITS  = $clog2(WORD_BITS);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Operation codes on the opcode port; code 3 means nothing
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_NEXT   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_INS_WR,
		BK_SCAN
	} bk_state_t;

endpackage

// ===== src/bps_front.sv =====
// Front end: accepts command words, drops unused codes, maps value to bitmap index.
// Depends on bps_pkg.
module bps_front #(
	parameter int VALUE_BITS = bps_pkg::VALUE_BITS_DEF
) (
	input  logic                         start,
	input  logic [1:0]                   opcode,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         q_full,
	input  logic                         init_busy,
	output logic                         busy,
	output logic                         push,
	output logic [VALUE_BITS+1:0]        push_data
);
	import bps_pkg::*;

	logic                  op_ok;
	logic [VALUE_BITS-1:0] idx;

	// Hold off new words while the queue is full or the first sweep runs
	assign busy = q_full | init_busy;

	// Drop the unused code; it changes nothing and gives no result
	always_comb begin
		op_ok = opcode inside {OP_INSERT, OP_NEXT, OP_CLEAR};
	end

	// Offset the signed value so the most negative value maps to bit 0
	assign idx       = {~value[VALUE_BITS-1], value[VALUE_BITS-2:0]};
	assign push      = start & ~busy & op_ok;
	assign push_data = {opcode, idx};

endmodule

// ===== src/bps_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on bps_pkg.
module bps_cmd_queue #(
	parameter int WIDTH = 18,
	parameter int DEPTH = bps_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);
	import bps_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = entry_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/bps_back.sv =====
// Back end: bitmap memory, insert read-modify-write, word-serial scan, clear sweep.
// Depends on bps_pkg.
module bps_back #(
	parameter int VALUE_BITS = bps_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [VALUE_BITS+1:0]        head,
	input  logic                         empty,
	output logic                         pop,
	output logic                         init_busy,
	output logic                         strobe,
	output logic signed [VALUE_BITS-1:0] sorted_value,
	output logic                         done_res
);
	import bps_pkg::*;

	localparam int ADDR_W    = VALUE_BITS - WORD_SEL_BITS;
	localparam int NUM_WORDS = 1 << ADDR_W;

	bk_state_t                 state_q, state_d;
	logic [WORD_BITS-1:0]      mem [NUM_WORDS];
	logic [WORD_BITS-1:0]      rd_q;
	logic [VALUE_BITS:0]       cursor_q;
	logic [ADDR_W-1:0]         scan_addr_q;
	logic [WORD_SEL_BITS-1:0]  bit_q;
	logic                      first_q;
	logic [ADDR_W-1:0]         sweep_q;
	logic                      init_q;
	logic                      strobe_q;
	logic [VALUE_BITS-1:0]     res_value_q;
	logic                      done_q;

	op_t                       hd_op;
	logic [VALUE_BITS-1:0]     hd_idx;
	logic [WORD_BITS-1:0]      masked;
	logic                      hit_any;
	logic [WORD_SEL_BITS-1:0]  hit_bit;
	logic [VALUE_BITS-1:0]     hit;
	logic                      last_word;

	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_waddr;
	logic [WORD_BITS-1:0]      mem_wdata;
	logic [ADDR_W-1:0]         mem_raddr;
	logic                      res_fire;
	logic                      res_done;
	logic [VALUE_BITS-1:0]     res_value;

	// Lowest set bit of a word: isolate it, then encode each index bit
	function automatic logic [WORD_SEL_BITS-1:0] lowest_bit(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0]     iso;
		logic [WORD_SEL_BITS-1:0] enc;
		iso = w & (~w + WORD_BITS'(1));
		enc = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso[i]) begin
				enc = enc | WORD_SEL_BITS'(i);
			end
		end
		return enc;
	endfunction

	assign hd_op     = op_t'(head[VALUE_BITS+1:VALUE_BITS]);
	assign hd_idx    = head[VALUE_BITS-1:0];
	assign init_busy = init_q;

	// Drop bits below the cursor in the first word of a scan
	assign masked    = first_q ? (rd_q & ({WORD_BITS{1'b1}} << bit_q)) : rd_q;
	assign hit_any   = |masked;
	assign hit_bit   = lowest_bit(masked);
	assign hit       = {scan_addr_q, hit_bit};
	assign last_word = (scan_addr_q == '1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (sweep_q == '1) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!empty) begin
					case (hd_op)
						OP_INSERT: state_d = BK_INS_WR;
						OP_NEXT:   state_d = cursor_q[VALUE_BITS] ? BK_IDLE : BK_SCAN;
						OP_CLEAR:  state_d = BK_CLEAR;
						default:   state_d = BK_IDLE;
					endcase
				end
			end
			BK_INS_WR: state_d = BK_IDLE;
			BK_SCAN: begin
				if (hit_any || last_word) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Memory control, queue pop and result
	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = scan_addr_q;
		mem_wdata = '0;
		mem_raddr = scan_addr_q;
		res_fire  = 1'b0;
		res_done  = 1'b0;
		res_value = '0;
		case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
			end
			BK_IDLE: begin
				pop = ~empty;
				case (hd_op)
					OP_INSERT: mem_raddr = hd_idx[VALUE_BITS-1:WORD_SEL_BITS];
					OP_NEXT: begin
						mem_raddr = cursor_q[VALUE_BITS-1:WORD_SEL_BITS];
						if (!empty && cursor_q[VALUE_BITS]) begin
							res_fire = 1'b1;
							res_done = 1'b1;
						end
					end
					default: mem_raddr = scan_addr_q;
				endcase
			end
			BK_INS_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rd_q | (WORD_BITS'(1) << bit_q);
			end
			BK_SCAN: begin
				mem_raddr = scan_addr_q + 1'b1;
				if (hit_any) begin
					res_fire  = 1'b1;
					res_value = {~hit[VALUE_BITS-1], hit[VALUE_BITS-2:0]};
				end else if (last_word) begin
					res_fire = 1'b1;
					res_done = 1'b1;
				end
			end
			default: pop = 1'b0;
		endcase
	end

	// Bitmap memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// Per-command working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			case (hd_op)
				OP_INSERT: begin
					scan_addr_q <= hd_idx[VALUE_BITS-1:WORD_SEL_BITS];
					bit_q       <= hd_idx[WORD_SEL_BITS-1:0];
				end
				OP_NEXT: begin
					scan_addr_q <= cursor_q[VALUE_BITS-1:WORD_SEL_BITS];
					bit_q       <= cursor_q[WORD_SEL_BITS-1:0];
				end
				default: bit_q <= bit_q;
			endcase
		end else if (state_q == BK_SCAN) begin
			scan_addr_q <= scan_addr_q + 1'b1;
		end
		res_value_q <= res_value;
		done_q      <= res_done;
	end

	// Sequencer state, cursor, sweep counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_CLEAR;
			cursor_q <= '0;
			sweep_q  <= '0;
			init_q   <= 1'b1;
			first_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= res_fire;
			if (pop && hd_op == OP_CLEAR) begin
				cursor_q <= '0;
				sweep_q  <= '0;
			end
			if (pop && hd_op == OP_NEXT) begin
				first_q <= 1'b1;
			end else if (state_q == BK_SCAN) begin
				first_q <= 1'b0;
			end
			if (state_q == BK_SCAN && hit_any) begin
				cursor_q <= {1'b0, hit} + {{VALUE_BITS{1'b0}}, 1'b1};
			end
			if (state_q == BK_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_q == '1) begin
					init_q <= 1'b0;
				end
			end
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = res_value_q;
	assign done_res     = done_q;

endmodule

// ===== src/bitmap_presence_sort_top.sv =====
// Insert is a read-modify-write of one bitmap word; clear writes zero to every bitmap word; next
// scans word by word from the cursor, through the single read port of the bitmap memory.
// A 2-deep queue takes words while next scans.
// Reset: async active low; busy stays high after reset while memory is zeroed.
// The result strobe is registered and the receiver cannot stall it.
module bitmap_presence_sort_top #(
	parameter int VALUE_BITS = bps_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   opcode,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         strobe,
	output logic signed [VALUE_BITS-1:0] sorted_value,
	output logic                         done_res
);
	import bps_pkg::*;

	localparam int CMD_W = VALUE_BITS + 2;

	logic             push;
	logic [CMD_W-1:0] push_data;
	logic [CMD_W-1:0] head;
	logic             empty;
	logic             full;
	logic             pop;
	logic             init_busy;

	// Accept and classify command words
	bps_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.start     (start),
		.opcode    (opcode),
		.value     (value),
		.q_full    (full),
		.init_busy (init_busy),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple front and back
	bps_cmd_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// Execute commands against the bitmap
	bps_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.init_busy    (init_busy),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.done_res     (done_res)
	);

endmodule

// ===== src/bps_checker.sv =====
// Port-level checker for the bitmap presence sort block, bound to the top level.
// Depends on bps_pkg and bitmap_presence_sort_top_macros.svh.
`include "bitmap_presence_sort_top_macros.svh"

module bps_checker #(
	parameter int VALUE_BITS = bps_pkg::VALUE_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   opcode,
	input logic signed [VALUE_BITS-1:0] value,
	input logic                         strobe,
	input logic signed [VALUE_BITS-1:0] sorted_value,
	input logic                         done_res
);
	import bps_pkg::*;

	localparam int MAX_OPEN = QUEUE_DEPTH + 1;

	logic       next_acc;
	logic       any_acc;
	logic [2:0] open_q;

	assign next_acc = start & ~busy & (opcode == OP_NEXT);
	assign any_acc  = start & ~busy & (value == value);

	// Count next words accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (next_acc && !strobe) begin
			open_q <= open_q + 1'b1;
		end else if (strobe && !next_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	// An exhausted scan reports a zero value
	`BPS_ASSERT_IMPL(a_done_zero, clk, arst_n, strobe && done_res, sorted_value == '0)
	// Every result answers an earlier next
	`BPS_ASSERT_IMPL(a_result_owed, clk, arst_n, strobe, open_q != '0)
	// Outstanding nexts never exceed queue plus the one in service
	`BPS_ASSERT_NEVER(a_open_bound, clk, arst_n, open_q > 3'(MAX_OPEN))
	// No word is taken while busy is high
	`BPS_ASSERT_NEVER(a_no_take_busy, clk, arst_n, any_acc && busy)

endmodule

bind bitmap_presence_sort_top bps_checker #(.VALUE_BITS(VALUE_BITS)) u_bps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.opcode       (opcode),
	.value        (value),
	.strobe       (strobe),
	.sorted_value (sorted_value),
	.done_res     (done_res)
);

// ===== sim/tb.sv =====
// Self-checking testbench for bitmap_presence_sort_top: directed and random command words,
// scoreboarded against an in-bench bitmap sort predictor. Depends on bps_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
	import bps_pkg::*;

	localparam int VAL_W       = VALUE_BITS_DEF;
	localparam int NUM_WORDS   = (1 << VAL_W) / WORD_BITS;
	localparam int ITEM_TARGET = 1600;
	localparam int DRAIN_WAIT  = (1 << (VAL_W - 5)) + 200;

	localparam logic [VAL_W-1:0] SIGN_FLIP = VAL_W'(1) << (VAL_W - 1);

	// One command word waiting to be sent
	typedef struct {
		logic [1:0]       op;
		logic [VAL_W-1:0] val;
		bit               drain;
	} sort_cmd_t;

	// One expected readout word
	typedef struct {
		logic [VAL_W-1:0] val;
		logic             done;
	} sorted_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [1:0]              opcode = 2'd0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    busy;
	logic                    strobe;
	logic signed [VAL_W-1:0] sorted_value;
	logic                    done_res;

	sort_cmd_t    cmd_q[$];
	sorted_word_t sorted_q[$];
	int           total_cmds = 0;
	int           taken_count = 0;
	int           popped_count = 0;
	int           mismatches = 0;

	// Predictor copy of the bitmap and the scan cursor
	bit [WORD_BITS-1:0] presence_map [NUM_WORDS];
	bit [VAL_W:0]       scan_pos = '0;

	bitmap_presence_sort_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.value        (value),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.done_res     (done_res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one accepted command word to the predictor
	task automatic sort_apply(input logic [1:0] op, input logic [VAL_W-1:0] val,
			output bit has_word, output sorted_word_t word_out);
		logic [VAL_W-1:0]     idx;
		logic [WORD_BITS-1:0] scan_word;
		logic [VAL_W:0]       hit;
		int                   w;
		int                   b;
		int                   first_w;
		bit                   found;
		has_word = 1'b0;
		word_out.val = '0;
		word_out.done = 1'b0;
		found = 1'b0;
		hit = '0;
		if (op == OP_INSERT) begin
			idx = val ^ SIGN_FLIP;
			presence_map[idx[VAL_W-1:WORD_SEL_BITS]][idx[WORD_SEL_BITS-1:0]] = 1'b1;
		end else if (op == OP_CLEAR) begin
			for (w = 0; w < NUM_WORDS; w++)
				presence_map[w] = '0;
			scan_pos = '0;
		end else if (op == OP_NEXT) begin
			has_word = 1'b1;
			if (scan_pos < (1 << VAL_W)) begin
				first_w = int'(scan_pos[VAL_W-1:WORD_SEL_BITS]);
				for (w = first_w; w < NUM_WORDS && !found; w++) begin
					scan_word = presence_map[w];
					// drop bits below the cursor in its own word
					if (w == first_w)
						scan_word &= {WORD_BITS{1'b1}} << scan_pos[WORD_SEL_BITS-1:0];
					if (scan_word != '0) begin
						b = 0;
						while (!scan_word[b])
							b++;
						hit = (VAL_W+1)'(w * WORD_BITS + b);
						found = 1'b1;
					end
				end
			end
			if (found) begin
				word_out.val = hit[VAL_W-1:0] ^ SIGN_FLIP;
				scan_pos = hit + 1'b1;
			end else begin
				word_out.done = 1'b1;
			end
		end
	endtask

	task automatic push_cmd(input logic [1:0] op, input logic [VAL_W-1:0] val, input bit drain);
		sort_cmd_t c;
		c.op = op;
		c.val = val;
		c.drain = drain;
		cmd_q.push_back(c);
		total_cmds++;
	endtask

	// Present command words at the falling edge; hold a word until it is taken
	always @(negedge clk) begin : driver
		bit just_taken;
		bit go;
		int idle_pct;
		just_taken = 1'b0;
		go = 1'b0;
		if (arst_n) begin
			if (popped_count != taken_count) begin
				cmd_q.pop_front();
				popped_count++;
				just_taken = 1'b1;
			end
			if (start && !just_taken) begin
				go = 1'b1;
			end else if (cmd_q.size() > 0) begin
				if (taken_count * 3 < total_cmds)
					idle_pct = 23;
				else if (taken_count * 3 < total_cmds * 2)
					idle_pct = 78;
				else
					idle_pct = 0;
				// hold a drain word back until every readout has come
				if (!(cmd_q[0].drain && sorted_q.size() > 0) &&
						$urandom_range(99) >= idle_pct)
					go = 1'b1;
			end
		end
		if (go) begin
			start  <= 1'b1;
			opcode <= cmd_q[0].op;
			value  <= cmd_q[0].val;
		end else begin
			start  <= 1'b0;
			opcode <= 2'($urandom);
			value  <= VAL_W'($urandom);
		end
	end

	// Check readout words and note accepted command words at the rising edge
	always @(posedge clk) begin : monitor
		sorted_word_t want;
		sorted_word_t pred;
		bit           has_word;
		if (arst_n) begin
			if (strobe !== 1'b0) begin
				if (sorted_q.size() == 0) begin
					$display("%0t: readout word with none expected: value %0d done %b",
						$time, sorted_value, done_res);
					mismatches++;
				end else begin
					want = sorted_q.pop_front();
					if (sorted_value !== want.val) begin
						$display("%0t: sorted_value expected %0d actual %0d", $time,
							$signed(want.val), sorted_value);
						mismatches++;
					end
					if (done_res !== want.done) begin
						$display("%0t: done_res expected %b actual %b", $time,
							want.done, done_res);
						mismatches++;
					end
				end
			end
			if (start && busy === 1'b0) begin
				sort_apply(opcode, value, has_word, pred);
				if (has_word)
					sorted_q.push_back(pred);
				taken_count++;
			end
		end
	end

	// Fill the command queue, then wait for the run to drain
	initial begin : stimulus
		int useful;
		int base;
		int span;
		int n_ins;
		int n_next;
		int k;
		int op;

		// empty store, extremes, duplicate, unused opcode
		push_cmd(OP_NEXT, '0, 1'b0);
		push_cmd(OP_INSERT, 16'sh8000, 1'b0);
		push_cmd(OP_INSERT, 16'sh7fff, 1'b0);
		push_cmd(OP_INSERT, 16'sh0000, 1'b0);
		push_cmd(OP_INSERT, 16'shffff, 1'b0);
		push_cmd(OP_INSERT, 16'sh0000, 1'b0);
		push_cmd(OP_INSERT, 16'sh0001, 1'b0);
		push_cmd(2'd3, 16'sh5a5a, 1'b0);
		for (k = 0; k < 5; k++)
			push_cmd(OP_NEXT, '0, 1'b0);
		// nothing left, then an insert below the cursor
		push_cmd(OP_NEXT, '0, 1'b0);
		push_cmd(OP_INSERT, -16'sd100, 1'b0);
		push_cmd(OP_NEXT, '0, 1'b0);
		// restart; insert above and below the cursor after running dry
		push_cmd(OP_CLEAR, 16'shaaaa, 1'b1);
		push_cmd(OP_INSERT, 16'sd5, 1'b0);
		push_cmd(OP_NEXT, '0, 1'b0);
		push_cmd(OP_NEXT, '0, 1'b0);
		push_cmd(OP_INSERT, 16'sd7, 1'b0);
		push_cmd(OP_NEXT, '0, 1'b0);
		push_cmd(OP_INSERT, 16'sd3, 1'b0);
		push_cmd(OP_NEXT, '0, 1'b0);
		push_cmd(OP_CLEAR, '0, 1'b0);
		push_cmd(OP_NEXT, '0, 1'b0);
		useful = total_cmds - 1;

		// random part: mostly clear, clustered inserts, readout; some noise
		while (useful < ITEM_TARGET) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(9) < 8) begin
					push_cmd(OP_CLEAR, VAL_W'($urandom), $urandom_range(19) == 0);
					useful++;
				end
				base = $urandom_range((1 << VAL_W) - 1);
				span = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(63);
				n_ins = $urandom_range(12, 1);
				for (k = 0; k < n_ins; k++) begin
					push_cmd(OP_INSERT, VAL_W'(base + $urandom_range(span)), 1'b0);
					useful++;
				end
				n_next = $urandom_range(n_ins + 2, 1);
				for (k = 0; k < n_next; k++) begin
					if ($urandom_range(5) == 0) begin
						push_cmd(OP_INSERT, VAL_W'(base + $urandom_range(span)), 1'b0);
						useful++;
					end
					push_cmd(OP_NEXT, VAL_W'($urandom), 1'b0);
					useful++;
				end
			end else begin
				n_ins = $urandom_range(4, 1);
				for (k = 0; k < n_ins; k++) begin
					op = $urandom_range(3);
					push_cmd(2'(op), VAL_W'($urandom), 1'b0);
					if (op != 3)
						useful++;
				end
			end
		end

		// release reset at a falling clock edge
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		while (taken_count < total_cmds)
			@(posedge clk);
		while (sorted_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Give up after a generous fixed time
	initial begin : watchdog
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
